/* hdl/rank_assign_sort_top_defines.svh */
// Assertion macros shared by the rank assignment sorter RTL.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef RANK_ASSIGN_SORT_TOP_DEFINES_SVH
`define RANK_ASSIGN_SORT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rank sorter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rank sorter assertion failed");

`endif

/* hdl/ras_pkg.sv */
// Package of the rank assignment sorter: field widths, defaults and the
// control struct between the sequencer and the compare unit. No dependencies.
package ras_pkg;

    // Fixed payload widths.
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;

    // Default capacity of the value store.
    localparam int MAX_ITEMS_DEF = 64;

    // Control handed from the sequencer to the shared compare unit.
    typedef struct packed {
        logic load_x;      // capture the element being ranked, clear the count
        logic accum;       // compare the read element and count it if lower
        logic m_before_k;  // the read element arrived before the ranked one
    } t_cmp_ctrl;

endpackage

/* hdl/ras_if.sv */
// Valid/ready channel interfaces of the rank assignment sorter.
// Depends on ras_pkg for the payload widths.
interface ras_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [ras_pkg::VALUE_W-1:0] value;
    logic                          last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface ras_out_if;
    logic                        valid;
    logic                        ready;
    logic [ras_pkg::RANK_W-1:0]  rank;
    logic                        last_out;
    logic                        truncated;

    modport source (output valid, output rank, output last_out, output truncated, input ready);
    modport sink   (input valid, input rank, input last_out, input truncated, output ready);
endinterface

/* hdl/ras_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ras_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ras_rank_cnt.sv */
// Shared compare unit: one signed 32-bit compare and a rank counter.
// Depends on ras_pkg for the control struct and the value width.
module ras_rank_cnt #(
    parameter int AW = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ras_pkg::t_cmp_ctrl          i_ctrl,
    input  logic [ras_pkg::VALUE_W-1:0] i_data,
    output logic [AW-1:0]               o_rank
);

    logic signed [ras_pkg::VALUE_W-1:0] r_x;
    logic [AW-1:0]                      r_acc;
    logic [AW-1:0]                      n_acc;
    logic signed [ras_pkg::VALUE_W-1:0] y;
    logic                               lower;

    // The read element ranks below x if it is smaller, or equal and earlier.
    assign y     = signed'(i_data);
    assign lower = (y < r_x) || ((y == r_x) && i_ctrl.m_before_k);

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.load_x) begin
            n_acc = '0;
        end else if (i_ctrl.accum && lower) begin
            n_acc = r_acc + AW'(1);
        end
    end

    // The element under ranking is held for the whole sweep.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_x) begin
            r_x <= y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_rank = r_acc;

endmodule

/* hdl/rank_assign_sort_top.sv */
// Top level of the rank assignment sorter: sequencer, value store, compare unit.
// Depends on ras_pkg, ras_if, ras_ram, ras_rank_cnt and the defines header.
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+-------------------------------
//  i_in     | in  | valid/ready, sink  | value (s32), last_in
//  o_out    | out | valid/ready, source| rank (6b), last_out, truncated
//
// Loading accepts one request per cycle; the store is written at its next free slot.
// After the last request, each stored element is ranked in turn: one RAM read fetches
// it, the compare unit captures it, a sweep reads every stored element through the
// single RAM read port into the shared comparator, and the rank is then offered.
// Synchronous active-low reset clears the count, the overflow flag and the sequencer.
// A stalled output holds the sequencer; no input is taken until the list is out.
`include "rank_assign_sort_top_defines.svh"

module rank_assign_sort_top #(
    parameter int MAX_ITEMS = ras_pkg::MAX_ITEMS_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    ras_in_if.sink        i_in,
    ras_out_if.source     o_out
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] FULL     = CW'(MAX_ITEMS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ITEMS - 1);

    // Sequencer states.
    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_FETCHX = 3'd1;
    localparam logic [2:0] S_LOADX  = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_m, n_m;
    logic [AW-1:0] r_last, n_last;

    logic                        in_acc;
    logic                        out_acc;
    logic                        full;
    logic                        ram_we;
    logic [AW-1:0]               ram_raddr;
    logic [ras_pkg::VALUE_W-1:0] ram_rdata;
    ras_pkg::t_cmp_ctrl          cmp_ctrl;
    logic [AW-1:0]               cmp_rank;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign full    = (r_cnt == FULL);
    assign ram_we  = in_acc && !full;

    // Read address: the ranked element first, then a sweep over the whole list.
    always_comb begin
        case (r_state)
            S_FETCHX: ram_raddr = r_k;
            S_LOADX:  ram_raddr = '0;
            S_SWEEP:  ram_raddr = (r_m == r_last) ? r_m : r_m + AW'(1);
            default:  ram_raddr = r_k;
        endcase
    end

    ras_ram #(
        .WIDTH (ras_pkg::VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control for the shared compare unit; read data in the sweep belongs to r_m.
    assign cmp_ctrl.load_x     = (r_state == S_LOADX);
    assign cmp_ctrl.accum      = (r_state == S_SWEEP);
    assign cmp_ctrl.m_before_k = (r_m < r_k);

    ras_rank_cnt #(
        .AW (AW)
    ) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cmp_ctrl),
        .i_data  (ram_rdata),
        .o_rank  (cmp_rank)
    );

    // Sequencer next-state logic.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_k     = r_k;
        n_m     = r_m;
        n_last  = r_last;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                    if (i_in.last_in) begin
                        n_last  = full ? LAST_IDX : r_cnt[AW-1:0];
                        n_k     = '0;
                        n_state = S_FETCHX;
                    end
                end
            end
            S_FETCHX: begin
                n_state = S_LOADX;
            end
            S_LOADX: begin
                n_m     = '0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (r_m == r_last) begin
                    n_state = S_OUT;
                end else begin
                    n_m = r_m + AW'(1);
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    if (r_k == r_last) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_FETCHX;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_k     <= '0;
            r_m     <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_k     <= n_k;
            r_m     <= n_m;
            r_last  <= n_last;
        end
    end

    // Channel outputs.
    assign i_in.ready      = (r_state == S_LOAD);
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.rank      = ras_pkg::RANK_W'(cmp_rank);
    assign o_out.last_out  = (r_k == r_last);
    assign o_out.truncated = r_ovf;

    // The final result of a list returns the block to an empty store.
    `RAS_ASSERT_NXT(a_clear_after_list, i_clk, i_rst_n, out_acc && o_out.last_out, (r_cnt == '0) && !r_ovf)
    // A request that finds the store full marks the list as truncated.
    `RAS_ASSERT_NXT(a_overflow_flags, i_clk, i_rst_n, in_acc && full, r_ovf)
    // A rank never reaches the number of stored elements.
    `RAS_ASSERT_IMP(a_rank_in_range, i_clk, i_rst_n, o_out.valid, cmp_rank <= r_last)
    // The sweep never addresses beyond the last stored element.
    `RAS_ASSERT_IMP(a_sweep_bound, i_clk, i_rst_n, r_state == S_SWEEP, r_m <= r_last)

endmodule

/* bench/tb_rank_assign_sort_top.sv */
// Testbench of the rank assignment sorter: directed lists, then random lists with idling.
// Depends on ras_pkg, the ras_in_if/ras_out_if interfaces and rank_assign_sort_top.
module tb_rank_assign_sort_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS     = ras_pkg::MAX_ITEMS_DEF;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD     = 600;
    localparam int HOLD_AT       = 30;
    localparam int RAND_ITEMS    = 285;
    localparam int DIR_N         = 17;

    // One result of a list: the rank of one stored element.
    typedef struct packed {
        logic [ras_pkg::RANK_W-1:0] rank;
        logic                       last_out;
        logic                       truncated;
    } t_rank_res;

    // One directed request; typed rows carry the rank that can be read off directly.
    typedef struct packed {
        logic signed [ras_pkg::VALUE_W-1:0] value;
        logic                               last;
        logic                               typed;
        logic [ras_pkg::RANK_W-1:0]         rank;
    } t_dir_row;

    localparam logic signed [ras_pkg::VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [ras_pkg::VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    t_dir_row dir_rows [DIR_N] = '{
        // Single element list.
        '{32'sd0,         1'b1, 1'b1, 6'd0},
        // Extremes of the value range.
        '{VAL_MAX,        1'b0, 1'b1, 6'd4},
        '{VAL_MIN,        1'b0, 1'b1, 6'd0},
        '{-32'sd1,        1'b0, 1'b1, 6'd1},
        '{32'sd0,         1'b0, 1'b1, 6'd2},
        '{32'sd1,         1'b1, 1'b1, 6'd3},
        // Equal values are ranked by arrival.
        '{32'sd5,         1'b0, 1'b1, 6'd0},
        '{32'sd5,         1'b0, 1'b1, 6'd1},
        '{32'sd5,         1'b1, 1'b1, 6'd2},
        // Descending order.
        '{32'sd3,         1'b0, 1'b1, 6'd2},
        '{32'sd2,         1'b0, 1'b1, 6'd1},
        '{32'sd1,         1'b1, 1'b1, 6'd0},
        // Alternating bit patterns; the first one is negative.
        '{32'hAAAA_AAAA,  1'b0, 1'b1, 6'd0},
        '{32'h5555_5555,  1'b1, 1'b1, 6'd1},
        // Mixed list left to the predictor.
        '{32'h1234_5678,  1'b0, 1'b0, 6'd0},
        '{-32'sd999,      1'b0, 1'b0, 6'd0},
        '{32'h0000_ffff,  1'b1, 1'b0, 6'd0}
    };

    logic i_clk;
    logic i_rst_n;

    ras_in_if  in_if ();
    ras_out_if out_if ();

    rank_assign_sort_top #(
        .MAX_ITEMS(MAX_ITEMS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Predictor state: the list being loaded and the ranks still to come.
    logic signed [ras_pkg::VALUE_W-1:0] list_vals_q [$];
    int                                 list_typed_q [$];
    bit                                 list_dropped;
    t_rank_res                          rank_expect_q [$];
    int                                 mismatch_cnt;
    int                                 results_seen;

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: the run ends at a generous cycle limit.
    initial begin
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("simulation failed");
        $finish;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch on %s at result %0d: expected %0d, got %0d",
                 what, results_seen, want, got);
        mismatch_cnt++;
    endtask

    // Gap length: mostly short, a few long, none in a burst.
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Folds one accepted request into the list; on the last one, ranks the list.
    task automatic note_request(input logic signed [ras_pkg::VALUE_W-1:0] v, input logic l,
                                input int typed_rank);
        int        n;
        int        r;
        t_rank_res res;
        if (list_vals_q.size() < MAX_ITEMS) begin
            list_vals_q.push_back(v);
            list_typed_q.push_back(typed_rank);
        end else begin
            list_dropped = 1'b1;
        end
        if (l) begin
            n = list_vals_q.size();
            for (int k = 0; k < n; k++) begin
                r = 0;
                for (int m = 0; m < n; m++) begin
                    if (list_vals_q[m] < list_vals_q[k] ||
                        (list_vals_q[m] == list_vals_q[k] && m < k))
                        r++;
                end
                res.rank      = (list_typed_q[k] >= 0) ? ras_pkg::RANK_W'(list_typed_q[k])
                                                       : ras_pkg::RANK_W'(r);
                res.last_out  = (k == n - 1);
                res.truncated = list_dropped;
                rank_expect_q.push_back(res);
            end
            list_vals_q.delete();
            list_typed_q.delete();
            list_dropped = 1'b0;
        end
    endtask

    // Offers one request after a random gap and waits until it is taken.
    task automatic drive_request(input logic signed [ras_pkg::VALUE_W-1:0] v, input logic l,
                                 input int typed_rank, input bit burst);
        int gap;
        gap = pick_gap(burst);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.value   <= v;
        in_if.last_in <= l;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        note_request(v, l, typed_rank);
    endtask

    // Stops offering until every expected rank has come out.
    task automatic pause_until_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (rank_expect_q.size() != 0);
    endtask

    // Random list element: full range, a narrow range for ties, or the extremes.
    function automatic logic signed [ras_pkg::VALUE_W-1:0] rand_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 7)) - 32'sd4;
            default: begin
                case ($urandom_range(0, 5))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return -32'sd1;
                    3: return 32'sd0;
                    4: return 32'sd1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Sink side: checks each accepted rank and stalls at random.
    initial begin
        t_rank_res want;
        int        stall;
        bit        burst;
        stall = 0;
        burst = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (rank_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, 32'(out_if.rank));
                end else begin
                    want = rank_expect_q.pop_front();
                    if (out_if.rank !== want.rank)
                        report_mismatch("rank", 32'(want.rank), 32'(out_if.rank));
                    if (out_if.last_out !== want.last_out)
                        report_mismatch("last_out", 32'(want.last_out),
                                        32'(out_if.last_out));
                    if (out_if.truncated !== want.truncated)
                        report_mismatch("truncated", 32'(want.truncated),
                                        32'(out_if.truncated));
                end
                results_seen++;
                if ($urandom_range(0, 49) == 0) burst = ~burst;
                stall = (results_seen == HOLD_AT) ? LONG_HOLD : pick_gap(burst);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Source side: reset, directed table, random lists, then the final verdict.
    initial begin
        int len;
        int mode;
        int li;
        int rand_items;
        bit burst;
        mismatch_cnt  = 0;
        results_seen  = 0;
        list_dropped  = 1'b0;
        in_if.valid   <= 1'b0;
        in_if.value   <= '0;
        in_if.last_in <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_N; k++)
            drive_request(dir_rows[k].value, dir_rows[k].last,
                          dir_rows[k].typed ? int'(dir_rows[k].rank) : -1, 1'b0);
        pause_until_drained();

        // Random lists: a full one first, overflowing ones early, the rest mostly short.
        li = 0;
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            case (li)
                0: len = MAX_ITEMS;
                2: len = MAX_ITEMS + 1;
                5: len = MAX_ITEMS + 6;
                default: begin
                    mode = $urandom_range(0, 99);
                    if (mode < 70)      len = $urandom_range(1, 6);
                    else if (mode < 95) len = $urandom_range(7, 20);
                    else                len = $urandom_range(30, MAX_ITEMS - 1);
                end
            endcase
            mode  = $urandom_range(0, 2);
            burst = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < len; j++)
                drive_request(rand_value(mode), j == len - 1, -1, burst);
            rand_items += (len > MAX_ITEMS) ? MAX_ITEMS : len;
            if (li == 3) pause_until_drained();
            li++;
        end

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && rank_expect_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
